// ===== rtl/kdsr_pkg.sv =====
// ============================================================================
// kdsr_pkg
// Shared types, codes and the key pair resolution function of the key
// debounce block.
// ============================================================================
package kdsr_pkg;

    // defaults of the top level parameters
    localparam int NUM_KEYS_DEF           = 256;
    localparam int MAX_FLUSH_PER_TICK_DEF = 32;
    localparam int MAX_DEBOUNCE_DEF       = 250;

    // configuration reset values
    localparam logic [7:0] DEBOUNCE_RST      = 8'd50;
    localparam logic [7:0] PAIR_A_FIRST_RST  = 8'd30;
    localparam logic [7:0] PAIR_A_SECOND_RST = 8'd32;
    localparam logic [7:0] PAIR_B_FIRST_RST  = 8'd105;
    localparam logic [7:0] PAIR_B_SECOND_RST = 8'd106;

    // configuration register indexes
    localparam logic [2:0] CFG_DEBOUNCE      = 3'd0;
    localparam logic [2:0] CFG_PAIR_A_EN     = 3'd1;
    localparam logic [2:0] CFG_PAIR_B_EN     = 3'd2;
    localparam logic [2:0] CFG_PAIR_A_FIRST  = 3'd3;
    localparam logic [2:0] CFG_PAIR_A_SECOND = 3'd4;
    localparam logic [2:0] CFG_PAIR_B_FIRST  = 3'd5;
    localparam logic [2:0] CFG_PAIR_B_SECOND = 3'd6;

    // input opcodes
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // key values
    localparam logic [1:0] KV_RELEASE = 2'd0;
    localparam logic [1:0] KV_PRESS   = 2'd1;
    localparam logic [1:0] KV_REPEAT  = 2'd2;
    localparam logic [1:0] KV_INVALID = 2'd3;

    // pair winner codes
    localparam logic [1:0] WIN_NONE   = 2'd0;
    localparam logic [1:0] WIN_FIRST  = 2'd1;
    localparam logic [1:0] WIN_SECOND = 2'd2;

    // one cleaned key event
    typedef struct packed {
        logic [7:0] key;
        logic [1:0] value;
    } res_t;

    // control from the sequencer to the result buffer
    typedef struct packed {
        logic push;
        logic fin;
        res_t beat;
    } buf_ctl_t;

    // status from the result buffer
    typedef struct packed {
        logic ready;
        logic holding;
    } buf_stat_t;

    // outcome of one pair resolution step
    typedef struct packed {
        logic [1:0] phys;
        logic [1:0] winner;
        res_t       r0;
        res_t       r1;
        logic [1:0] count;
    } pair_res_t;

    // last-input-priority step for one key of a pair
    function automatic pair_res_t pair_resolve(
        input logic [7:0] code,
        input logic       press,
        input logic [7:0] k1,
        input logic [7:0] k2,
        input logic [1:0] phys,
        input logic [1:0] winner
    );
        logic       idx;
        logic [7:0] other;
        logic [7:0] win_code;
        logic [1:0] own_m;
        logic [1:0] oth_m;
        pair_res_t  r;
        idx      = (code == k1) ? 1'b0 : 1'b1;
        other    = idx ? k1 : k2;
        win_code = (winner == WIN_FIRST) ? k1 : k2;
        own_m    = idx ? 2'b10 : 2'b01;
        oth_m    = idx ? 2'b01 : 2'b10;
        r.phys   = press ? (phys | own_m) : (phys & ~own_m);
        r.winner = winner;
        r.r0     = '{key: code, value: KV_RELEASE};
        r.r1     = '{key: code, value: KV_RELEASE};
        r.count  = 2'd0;
        if (press) begin
            if (winner != WIN_NONE && win_code == other) begin
                r.r0    = '{key: other, value: KV_RELEASE};
                r.r1    = '{key: code, value: KV_PRESS};
                r.count = 2'd2;
            end
            else begin
                r.r0    = '{key: code, value: KV_PRESS};
                r.count = 2'd1;
            end
            r.winner = idx ? WIN_SECOND : WIN_FIRST;
        end
        else if (winner != WIN_NONE && win_code == code) begin
            r.winner = WIN_NONE;
            r.r0     = '{key: code, value: KV_RELEASE};
            r.count  = 2'd1;
            if ((r.phys & oth_m) != 2'b00) begin
                r.winner = idx ? WIN_FIRST : WIN_SECOND;
                r.r1     = '{key: other, value: KV_PRESS};
                r.count  = 2'd2;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/kdsr_out_buf.sv =====
// ============================================================================
// kdsr_out_buf
// Result buffer: one hold stage that keeps the newest result until it is
// known whether it is the final one, and the output register.
// ============================================================================
module kdsr_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  kdsr_pkg::buf_ctl_t ctl,
    output kdsr_pkg::buf_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_key,
    output logic [1:0]         out_value,
    output logic               last
);
    import kdsr_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    res_t hold_reg;
    res_t hold_next;
    logic out_valid_reg;
    logic out_valid_next;
    res_t out_reg;
    res_t out_next;
    logic last_reg;
    logic last_next;
    logic can_move;
    logic move;

    // hand-over conditions
    assign can_move     = !out_valid_reg || out_ready;
    assign stat.ready   = !hold_valid_reg || can_move;
    assign stat.holding = hold_valid_reg;
    assign move         = hold_valid_reg && can_move && (ctl.push || ctl.fin);

    // next state of hold stage and output register
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        last_next       = last_reg;
        if (ctl.push && stat.ready)
        begin
            hold_valid_next = 1'b1;
            hold_next       = ctl.beat;
        end
        else if (move)
        begin
            hold_valid_next = 1'b0;
        end
        if (move)
        begin
            out_valid_next = 1'b1;
            out_next       = hold_reg;
            last_next      = ctl.fin;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_reg.key;
    assign out_value = out_reg.value;
    assign last      = last_reg;

endmodule

// ===== rtl/key_debounce_with_socd_resolver.sv =====
// ============================================================================
// key_debounce_with_socd_resolver
// Eager key debouncer with last-input-priority resolution for two key pairs.
// Inputs are key events and 1 ms ticks; results are cleaned key events, the
// final one of each input marked by last. A tick walks the keys through a
// small sequencer that shares one 32-bit subtract and compare against the
// press time memory, until every key is checked or MAX_FLUSH_PER_TICK
// releases are flushed. The block takes no new input while an item is at
// work. Press times are kept in a memory with one valid flop per entry, so
// no clearing pass follows reset.
// ============================================================================
module key_debounce_with_socd_resolver #(
    parameter int NUM_KEYS           = kdsr_pkg::NUM_KEYS_DEF,
    parameter int MAX_FLUSH_PER_TICK = kdsr_pkg::MAX_FLUSH_PER_TICK_DEF,
    parameter int MAX_DEBOUNCE       = kdsr_pkg::MAX_DEBOUNCE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] key_code,
    input  logic [1:0] key_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_key,
    output logic [1:0] out_value,
    output logic       last
);
    import kdsr_pkg::*;

    localparam int KW = $clog2(NUM_KEYS);
    localparam int CW = $clog2(NUM_KEYS + 1);
    localparam int FW = $clog2(MAX_FLUSH_PER_TICK + 1);
    localparam logic [7:0] DB_MAX = 8'(MAX_DEBOUNCE);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EV     = 6'b000010,
        ST_SC_CHK = 6'b000100,
        ST_SC_CMP = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_FIN    = 6'b100000
    } state_t;

    // configuration
    logic [7:0] db_reg;
    logic       pa_en_reg;
    logic       pb_en_reg;
    logic [7:0] pa_first_reg;
    logic [7:0] pa_second_reg;
    logic [7:0] pb_first_reg;
    logic [7:0] pb_second_reg;

    // sequencer and key state
    state_t          state_reg, state_next;
    logic            op_reg, op_next;
    logic [7:0]      code_reg, code_next;
    logic [1:0]      val_reg, val_next;
    logic [31:0]     time_now_reg, time_now_next;
    logic [7:0]      since_reg, since_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic [FW-1:0]   flushed_reg, flushed_next;
    logic [NUM_KEYS-1:0] held_reg, held_next;
    logic [NUM_KEYS-1:0] pend_reg, pend_next;
    logic [NUM_KEYS-1:0] ptv_reg, ptv_next;
    logic [1:0]      pa_phys_reg, pa_phys_next;
    logic [1:0]      pa_win_reg, pa_win_next;
    logic [1:0]      pb_phys_reg, pb_phys_next;
    logic [1:0]      pb_win_reg, pb_win_next;
    res_t            slot0_reg, slot0_next;
    res_t            slot1_reg, slot1_next;
    logic [1:0]      slot_cnt_reg, slot_cnt_next;
    logic            emit_sel_reg, emit_sel_next;

    // press time memory
    logic [31:0]     press_time_mem [NUM_KEYS];
    logic [31:0]     pt_rd_reg;
    logic            ptv_rd_reg;
    logic [KW-1:0]   mem_rd_addr;
    logic            pt_we;

    // working signals
    logic            accept;
    logic [KW-1:0]   cur_idx;
    logic [7:0]      cur_key;
    logic [31:0]     stored_time;
    logic [31:0]     elapsed;
    logic            expired;
    logic            do_post;
    logic            do_repeat;
    logic            post_press;
    logic            in_a;
    logic            in_b;
    pair_res_t       pr;
    logic            event_ok;
    buf_ctl_t        buf_ctl;
    buf_stat_t       buf_stat;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_reg        <= DEBOUNCE_RST;
            pa_en_reg     <= 1'b0;
            pb_en_reg     <= 1'b0;
            pa_first_reg  <= PAIR_A_FIRST_RST;
            pa_second_reg <= PAIR_A_SECOND_RST;
            pb_first_reg  <= PAIR_B_FIRST_RST;
            pb_second_reg <= PAIR_B_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:      db_reg <= (cfg_data > DB_MAX) ? DB_MAX : cfg_data;
                CFG_PAIR_A_EN:     pa_en_reg <= cfg_data[0];
                CFG_PAIR_B_EN:     pb_en_reg <= cfg_data[0];
                CFG_PAIR_A_FIRST:  pa_first_reg <= cfg_data;
                CFG_PAIR_A_SECOND: pa_second_reg <= cfg_data;
                CFG_PAIR_B_FIRST:  pb_first_reg <= cfg_data;
                CFG_PAIR_B_SECOND: pb_second_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // current key under work
    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign cur_idx     = (state_reg == ST_EV) ? code_reg[KW-1:0] : scan_reg[KW-1:0];
    assign cur_key     = (state_reg == ST_EV) ? code_reg : 8'(scan_reg[KW-1:0]);
    assign mem_rd_addr = (state_reg == ST_IDLE) ? key_code[KW-1:0] : scan_reg[KW-1:0];
    assign event_ok    = ({1'b0, key_code} < 9'(NUM_KEYS)) && (key_value != KV_INVALID);

    // shared elapsed time compare
    assign stored_time = ptv_rd_reg ? pt_rd_reg : 32'd0;
    assign elapsed     = time_now_reg - stored_time;
    assign expired     = elapsed >= {24'd0, db_reg};

    // pair resolution for the posted key
    assign post_press = (state_reg == ST_EV) && (val_reg == KV_PRESS);
    assign in_a = pa_en_reg && (cur_key == pa_first_reg || cur_key == pa_second_reg);
    assign in_b = pb_en_reg && (cur_key == pb_first_reg || cur_key == pb_second_reg);
    assign pr   = in_a ? pair_resolve(cur_key, post_press, pa_first_reg, pa_second_reg,
                                      pa_phys_reg, pa_win_reg)
                       : pair_resolve(cur_key, post_press, pb_first_reg, pb_second_reg,
                                      pb_phys_reg, pb_win_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        code_next     = code_reg;
        val_next      = val_reg;
        time_now_next = time_now_reg;
        since_next    = since_reg;
        scan_next     = scan_reg;
        flushed_next  = flushed_reg;
        held_next     = held_reg;
        pend_next     = pend_reg;
        ptv_next      = ptv_reg;
        pa_phys_next  = pa_phys_reg;
        pa_win_next   = pa_win_reg;
        pb_phys_next  = pb_phys_reg;
        pb_win_next   = pb_win_reg;
        slot0_next    = slot0_reg;
        slot1_next    = slot1_reg;
        slot_cnt_next = 2'd0;
        emit_sel_next = emit_sel_reg;
        pt_we         = 1'b0;
        do_post       = 1'b0;
        do_repeat     = 1'b0;
        buf_ctl.push  = 1'b0;
        buf_ctl.fin   = 1'b0;
        buf_ctl.beat  = emit_sel_reg ? slot1_reg : slot0_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = opcode;
                    code_next = key_code;
                    val_next  = key_value;
                    if (opcode == OP_TICK)
                    begin
                        time_now_next = time_now_reg + 32'd1;
                        if (since_reg != 8'hFF)
                        begin
                            since_next = since_reg + 8'd1;
                        end
                        scan_next    = '0;
                        flushed_next = '0;
                        state_next   = ST_SC_CHK;
                    end
                    else
                    begin
                        state_next = event_ok ? ST_EV : ST_FIN;
                    end
                end
            end

            // key event decision
            ST_EV:
            begin
                case (val_reg)
                    KV_PRESS:
                    begin
                        if (since_reg >= db_reg)
                        begin
                            if (!held_reg[cur_idx])
                            begin
                                do_post            = 1'b1;
                                held_next[cur_idx] = 1'b1;
                                ptv_next[cur_idx]  = 1'b1;
                                pt_we              = 1'b1;
                            end
                            pend_next[cur_idx] = 1'b0;
                        end
                    end
                    KV_RELEASE:
                    begin
                        if (!expired)
                        begin
                            pend_next[cur_idx] = 1'b1;
                        end
                        else
                        begin
                            do_post            = 1'b1;
                            held_next[cur_idx] = 1'b0;
                            pend_next[cur_idx] = 1'b0;
                        end
                    end
                    KV_REPEAT:
                    begin
                        do_repeat = held_reg[cur_idx];
                    end
                    default: ;
                endcase
            end

            // look for a pending release
            ST_SC_CHK:
            begin
                if (scan_reg == CW'(NUM_KEYS) || flushed_reg == FW'(MAX_FLUSH_PER_TICK))
                begin
                    state_next = ST_FIN;
                end
                else if (pend_reg[cur_idx])
                begin
                    state_next = ST_SC_CMP;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end

            // flush the release once its deadline is reached
            ST_SC_CMP:
            begin
                if (expired)
                begin
                    do_post            = 1'b1;
                    held_next[cur_idx] = 1'b0;
                    pend_next[cur_idx] = 1'b0;
                    flushed_next       = flushed_reg + FW'(1);
                end
                scan_next = scan_reg + CW'(1);
            end

            // hand results to the buffer, one per cycle while the buffer is ready
            ST_EMIT:
            begin
                slot_cnt_next = slot_cnt_reg;
                buf_ctl.push  = 1'b1;
                if (buf_stat.ready)
                begin
                    if (emit_sel_reg || slot_cnt_reg == 2'd1)
                    begin
                        state_next = (op_reg == OP_TICK) ? ST_SC_CHK : ST_FIN;
                    end
                    else
                    begin
                        emit_sel_next = 1'b1;
                    end
                end
            end

            // mark the final beat
            ST_FIN:
            begin
                buf_ctl.fin = 1'b1;
                if (buf_stat.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // results of the posted key
        if (do_post)
        begin
            if (in_a)
            begin
                pa_phys_next  = pr.phys;
                pa_win_next   = pr.winner;
                slot0_next    = pr.r0;
                slot1_next    = pr.r1;
                slot_cnt_next = pr.count;
            end
            else if (in_b)
            begin
                pb_phys_next  = pr.phys;
                pb_win_next   = pr.winner;
                slot0_next    = pr.r0;
                slot1_next    = pr.r1;
                slot_cnt_next = pr.count;
            end
            else
            begin
                slot0_next    = '{key: cur_key, value: post_press ? KV_PRESS : KV_RELEASE};
                slot_cnt_next = 2'd1;
            end
        end
        else if (do_repeat)
        begin
            slot0_next    = '{key: cur_key, value: KV_REPEAT};
            slot_cnt_next = 2'd1;
        end

        // leave the work states
        if (state_reg == ST_EV || state_reg == ST_SC_CMP)
        begin
            emit_sel_next = 1'b0;
            if (slot_cnt_next != 2'd0)
            begin
                state_next = ST_EMIT;
            end
            else
            begin
                state_next = (op_reg == OP_TICK) ? ST_SC_CHK : ST_FIN;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            time_now_reg <= 32'd0;
            since_reg    <= 8'd0;
            held_reg     <= '0;
            pend_reg     <= '0;
            ptv_reg      <= '0;
            pa_phys_reg  <= 2'b00;
            pa_win_reg   <= WIN_NONE;
            pb_phys_reg  <= 2'b00;
            pb_win_reg   <= WIN_NONE;
            scan_reg     <= '0;
            flushed_reg  <= '0;
            slot_cnt_reg <= 2'd0;
            emit_sel_reg <= 1'b0;
            op_reg       <= OP_EVENT;
        end
        else
        begin
            state_reg    <= state_next;
            time_now_reg <= time_now_next;
            since_reg    <= since_next;
            held_reg     <= held_next;
            pend_reg     <= pend_next;
            ptv_reg      <= ptv_next;
            pa_phys_reg  <= pa_phys_next;
            pa_win_reg   <= pa_win_next;
            pb_phys_reg  <= pb_phys_next;
            pb_win_reg   <= pb_win_next;
            scan_reg     <= scan_next;
            flushed_reg  <= flushed_next;
            slot_cnt_reg <= slot_cnt_next;
            emit_sel_reg <= emit_sel_next;
            op_reg       <= op_next;
        end
    end

    // item payload and result slots
    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        val_reg   <= val_next;
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // press time memory, registered read
    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            press_time_mem[code_reg[KW-1:0]] <= time_now_reg;
        end
        pt_rd_reg  <= press_time_mem[mem_rd_addr];
        ptv_rd_reg <= ptv_reg[mem_rd_addr];
    end

    // result buffer
    kdsr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (buf_ctl),
        .stat      (buf_stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_key   (out_key),
        .out_value (out_value),
        .last      (last)
    );

    // checks
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !buf_stat.holding)
        else $error("result held back while idle");

    a_flush_limit: assert property (@(posedge clk) disable iff (!rst_n)
        flushed_reg <= FW'(MAX_FLUSH_PER_TICK))
        else $error("too many keys flushed in one tick");

    a_winner_code: assert property (@(posedge clk) disable iff (!rst_n)
        (pa_win_reg != 2'd3) && (pb_win_reg != 2'd3))
        else $error("pair winner out of range");

    a_fin_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (state_reg == ST_FIN || state_reg == ST_IDLE))
        else $error("sequencer left the final state wrongly");

endmodule

// ===== tb/tb_key_debounce_with_socd_resolver.sv =====
// ============================================================================
// tb_key_debounce_with_socd_resolver
// Self-checking bench for the key debouncer with pair resolution. Key events
// and ticks go in over a valid/ready channel; a cycle-free model of the
// debounce, flush and last-input-priority rules builds the queue of cleaned
// events that every output beat is checked against, field by field.
// ============================================================================
module tb_key_debounce_with_socd_resolver;
    import kdsr_pkg::*;

    localparam int KEYS          = NUM_KEYS_DEF;
    localparam int FLUSH_CAP     = MAX_FLUSH_PER_TICK_DEF;
    localparam int DEB_CAP       = MAX_DEBOUNCE_DEF;
    localparam int RESULT_CAP    = 64;
    localparam int SETTLE_CYCLES = 600;
    localparam int BURST_KEYS    = 40;

    typedef struct {
        logic [7:0] key;
        logic [1:0] value;
        logic       last;
    } clean_ev_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_index = CFG_DEBOUNCE;
    logic [7:0] cfg_data  = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       opcode    = OP_EVENT;
    logic [7:0] key_code  = 8'd0;
    logic [1:0] key_value = KV_RELEASE;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_key;
    logic [1:0] out_value;
    logic       last;

    // traffic shaping, in percent: of beats with a gap in front, of cycles with a stall
    int idle_pct  = 0;
    int stall_pct = 0;
    int faults    = 0;

    // cleaned events still to come out, oldest first
    clean_ev_t clean_q[$];
    clean_ev_t head_ev;
    int        item_start;

    // mirror of the configuration
    logic [7:0]  deb_ms;
    logic        a_on, b_on;
    logic [7:0]  a_key1, a_key2, b_key1, b_key2;

    // mirror of the key state
    logic [31:0] now_ms;
    logic [7:0]  uptime_ms;
    logic        held [KEYS];
    logic [31:0] pressed_at [KEYS];
    logic        release_due [KEYS];
    logic [1:0]  a_down, b_down, a_owner, b_owner;

    key_debounce_with_socd_resolver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .key_code  (key_code),
        .key_value (key_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_key   (out_key),
        .out_value (out_value),
        .last      (last)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // key state mirror
    // ------------------------------------------------------------------------

    task automatic clear_key_state();
        int k;
        deb_ms    = DEBOUNCE_RST;
        a_on      = 1'b0;
        b_on      = 1'b0;
        a_key1    = PAIR_A_FIRST_RST;
        a_key2    = PAIR_A_SECOND_RST;
        b_key1    = PAIR_B_FIRST_RST;
        b_key2    = PAIR_B_SECOND_RST;
        now_ms    = 32'd0;
        uptime_ms = 8'd0;
        a_down    = 2'b00;
        b_down    = 2'b00;
        a_owner   = WIN_NONE;
        b_owner   = WIN_NONE;
        for (k = 0; k < KEYS; k++)
        begin
            held[k]        = 1'b0;
            pressed_at[k]  = 32'd0;
            release_due[k] = 1'b0;
        end
    endtask

    // one cleaned event, capped per input item
    function automatic void push_clean(logic [7:0] k, logic [1:0] v);
        if (clean_q.size() - item_start < RESULT_CAP)
            clean_q.push_back('{key: k, value: v, last: 1'b0});
    endfunction

    // newest key of a pair wins; releasing the winner brings the other back
    task automatic resolve_pair(input logic [7:0] code, input logic down,
                                input logic [7:0] k1, input logic [7:0] k2,
                                inout logic [1:0] phys, inout logic [1:0] owner);
        logic       second;
        logic [7:0] other;
        logic [7:0] owner_key;
        logic [1:0] own_bit;
        logic [1:0] other_bit;
        second    = (code != k1);
        other     = second ? k1 : k2;
        owner_key = (owner == WIN_FIRST) ? k1 : k2;
        own_bit   = second ? 2'b10 : 2'b01;
        other_bit = ~own_bit;
        if (down)
            phys = phys | own_bit;
        else
            phys = phys & ~own_bit;
        if (down)
        begin
            if (owner != WIN_NONE && owner_key == other)
                push_clean(other, KV_RELEASE);
            owner = second ? WIN_SECOND : WIN_FIRST;
            push_clean(code, KV_PRESS);
        end
        else if (owner != WIN_NONE && owner_key == code)
        begin
            owner = WIN_NONE;
            push_clean(code, KV_RELEASE);
            if ((phys & other_bit) != 2'b00)
            begin
                owner = second ? WIN_FIRST : WIN_SECOND;
                push_clean(other, KV_PRESS);
            end
        end
    endtask

    // pair A takes a code that sits in both pairs
    task automatic route_event(logic [7:0] code, logic down);
        if (a_on && (code == a_key1 || code == a_key2))
            resolve_pair(code, down, a_key1, a_key2, a_down, a_owner);
        else if (b_on && (code == b_key1 || code == b_key2))
            resolve_pair(code, down, b_key1, b_key2, b_down, b_owner);
        else
            push_clean(code, down ? KV_PRESS : KV_RELEASE);
    endtask

    // cleaned events caused by one accepted input beat
    task automatic clean_item(logic op, logic [7:0] code, logic [1:0] val);
        int          k;
        int          flushed;
        logic [31:0] age;
        item_start = clean_q.size();
        if (op == OP_TICK)
        begin
            now_ms = now_ms + 32'd1;
            if (uptime_ms != 8'hFF)
                uptime_ms = uptime_ms + 8'd1;
            flushed = 0;
            for (k = 0; k < KEYS && flushed < FLUSH_CAP; k++)
            begin
                age = now_ms - pressed_at[k];
                if (release_due[k] && age >= 32'(deb_ms))
                begin
                    route_event(8'(k), 1'b0);
                    held[k]        = 1'b0;
                    release_due[k] = 1'b0;
                    flushed++;
                end
            end
        end
        else if (int'(code) < KEYS)
        begin
            case (val)
                KV_PRESS:
                begin
                    if (uptime_ms >= deb_ms)
                    begin
                        if (!held[code])
                        begin
                            route_event(code, 1'b1);
                            held[code]       = 1'b1;
                            pressed_at[code] = now_ms;
                        end
                        release_due[code] = 1'b0;
                    end
                end
                KV_RELEASE:
                begin
                    age = now_ms - pressed_at[code];
                    if (age < 32'(deb_ms))
                        release_due[code] = 1'b1;
                    else
                    begin
                        route_event(code, 1'b0);
                        held[code]        = 1'b0;
                        release_due[code] = 1'b0;
                    end
                end
                KV_REPEAT:
                begin
                    if (held[code])
                        push_clean(code, KV_REPEAT);
                end
                default: ;
            endcase
        end
        if (clean_q.size() > item_start)
            clean_q[$].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one input beat, with an optional gap in front; valid stays up after
    task automatic send_beat(logic op, logic [7:0] code, logic [1:0] val);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(280, 1) : $urandom_range(6, 1);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        key_code  <= code;
        key_value <= val;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        clean_item(op, code, val);
    endtask

    // stop sending, wait for every cleaned event, then let silent work end
    task automatic wait_quiet(int settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (clean_q.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // one register write; the caller drops the write enable afterwards
    task automatic put_reg(logic [2:0] idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_DEBOUNCE:      deb_ms = (int'(data) > DEB_CAP) ? 8'(DEB_CAP) : data;
            CFG_PAIR_A_EN:     a_on   = data[0];
            CFG_PAIR_B_EN:     b_on   = data[0];
            CFG_PAIR_A_FIRST:  a_key1 = data;
            CFG_PAIR_A_SECOND: a_key2 = data;
            CFG_PAIR_B_FIRST:  b_key1 = data;
            CFG_PAIR_B_SECOND: b_key2 = data;
            default: ;
        endcase
    endtask

    // whole register set, only while the block is idle
    task automatic apply_config(logic [7:0] deb, logic a_en, logic b_en,
                                logic [7:0] a1, logic [7:0] a2,
                                logic [7:0] b1, logic [7:0] b2);
        put_reg(CFG_DEBOUNCE, deb);
        put_reg(CFG_PAIR_A_EN, {7'($urandom_range(127)), a_en});
        put_reg(CFG_PAIR_B_EN, {7'($urandom_range(127)), b_en});
        put_reg(CFG_PAIR_A_FIRST, a1);
        put_reg(CFG_PAIR_A_SECOND, a2);
        put_reg(CFG_PAIR_B_FIRST, b1);
        put_reg(CFG_PAIR_B_SECOND, b2);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // output beat checker and receiver stalls
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (clean_q.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("%0t: beat with nothing due: key=%0d value=%0d last=%0d",
                             $time, out_key, out_value, last);
            end
            else
            begin
                head_ev = clean_q.pop_front();
                if (out_key !== head_ev.key || out_value !== head_ev.value ||
                    last !== head_ev.last)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: beat mismatch: due key=%0d value=%0d last=%0d, %s%0d %s%0d %s%0d",
                                 $time, head_ev.key, head_ev.value, head_ev.last,
                                 "got key=", out_key, "value=", out_value, "last=", last);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // presses dropped in the opening window, parked release of an unheld key
    task automatic test_startup_window();
        idle_pct  = 0;
        stall_pct = 0;
        send_beat(OP_EVENT, 8'd10, KV_PRESS);
        send_beat(OP_EVENT, 8'd10, KV_REPEAT);
        send_beat(OP_EVENT, 8'd10, KV_RELEASE);
        send_beat(OP_EVENT, 8'd10, KV_INVALID);
        send_beat(OP_TICK, 8'd0, KV_RELEASE);
        // window above the ceiling is clamped, release still parked
        wait_quiet(SETTLE_CYCLES);
        apply_config(8'd255, 1'b0, 1'b0, PAIR_A_FIRST_RST, PAIR_A_SECOND_RST,
                     PAIR_B_FIRST_RST, PAIR_B_SECOND_RST);
        send_beat(OP_TICK, 8'hFF, KV_INVALID);
        // short window, the next tick flushes the parked release
        wait_quiet(SETTLE_CYCLES);
        apply_config(8'd2, 1'b0, 1'b0, PAIR_A_FIRST_RST, PAIR_A_SECOND_RST,
                     PAIR_B_FIRST_RST, PAIR_B_SECOND_RST);
        send_beat(OP_TICK, 8'd0, KV_PRESS);
    endtask

    // extreme codes, repeat, re-press cancelling an early release
    task automatic test_key_events();
        send_beat(OP_EVENT, 8'd0, KV_PRESS);
        send_beat(OP_EVENT, 8'd255, KV_PRESS);
        send_beat(OP_EVENT, 8'd255, KV_REPEAT);
        send_beat(OP_EVENT, 8'd255, KV_RELEASE);
        send_beat(OP_EVENT, 8'd255, KV_PRESS);
        send_beat(OP_TICK, 8'd255, KV_REPEAT);
        send_beat(OP_TICK, 8'd0, KV_PRESS);
        send_beat(OP_EVENT, 8'd0, KV_RELEASE);
        send_beat(OP_EVENT, 8'd255, KV_RELEASE);
    endtask

    // last-input priority, loser release, restore and overlapping pairs
    task automatic test_pair_priority();
        wait_quiet(SETTLE_CYCLES);
        apply_config(8'd0, 1'b1, 1'b1, 8'd0, 8'd255, 8'd255, 8'd106);
        send_beat(OP_EVENT, 8'd0, KV_PRESS);
        send_beat(OP_EVENT, 8'd255, KV_PRESS);
        send_beat(OP_EVENT, 8'd0, KV_RELEASE);
        send_beat(OP_EVENT, 8'd0, KV_PRESS);
        send_beat(OP_EVENT, 8'd0, KV_RELEASE);
        send_beat(OP_EVENT, 8'd106, KV_PRESS);
        send_beat(OP_EVENT, 8'd255, KV_RELEASE);
        send_beat(OP_EVENT, 8'd106, KV_RELEASE);
    endtask

    // more early releases than one tick may flush
    task automatic test_flush_burst();
        logic [7:0] burst [BURST_KEYS];
        bit         taken [KEYS];
        logic [7:0] pick;
        int         i, j;
        wait_quiet(SETTLE_CYCLES);
        idle_pct  = 0;
        stall_pct = 63;
        for (i = 0; i < BURST_KEYS; i++)
        begin
            do
                pick = 8'($urandom_range(255));
            while (taken[pick]);
            taken[pick] = 1'b1;
            burst[i]    = pick;
        end
        apply_config(8'd4, 1'b1, 1'b0, burst[0], burst[1],
                     PAIR_B_FIRST_RST, PAIR_B_SECOND_RST);
        for (i = 0; i < BURST_KEYS; i++)
            send_beat(OP_EVENT, burst[i], KV_PRESS);
        // release in shuffled order
        for (i = BURST_KEYS - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            pick     = burst[i];
            burst[i] = burst[j];
            burst[j] = pick;
        end
        for (i = 0; i < BURST_KEYS; i++)
            send_beat(OP_EVENT, burst[i], KV_RELEASE);
        repeat (6) send_beat(OP_TICK, 8'($urandom_range(255)), 2'($urandom_range(3)));
    endtask

    // random traffic on a small pool of keys around random pairs
    task automatic test_random_traffic(int count, int send_idle, int recv_stall,
                                       bit hold_mid);
        logic [7:0] pool [8];
        logic [7:0] code;
        int         i, r;
        wait_quiet(SETTLE_CYCLES);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        for (i = 0; i < 8; i++)
            pool[i] = 8'($urandom_range(255));
        if ($urandom_range(7) == 0)
            pool[1] = pool[0];
        if ($urandom_range(4) == 0)
            pool[2] = pool[1];
        apply_config(8'($urandom_range(6)), $urandom_range(3) != 0, $urandom_range(3) != 0,
                     pool[0], pool[1], pool[2], pool[3]);
        for (i = 0; i < count; i++)
        begin
            // hold back until every cleaned event has come out
            if (hold_mid && i == count / 2)
                wait_quiet(0);
            code = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : pool[$urandom_range(7)];
            r    = $urandom_range(99);
            if (r < 25)
                send_beat(OP_TICK, code, 2'($urandom_range(3)));
            else if (r < 55)
                send_beat(OP_EVENT, code, KV_PRESS);
            else if (r < 85)
                send_beat(OP_EVENT, code, KV_RELEASE);
            else if (r < 95)
                send_beat(OP_EVENT, code, KV_REPEAT);
            else
                send_beat(OP_EVENT, code, KV_INVALID);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clear_key_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_startup_window();
        test_key_events();
        test_pair_priority();
        test_flush_burst();
        test_random_traffic(17, 0, 0, 1'b0);
        test_random_traffic(17, 63, 0, 1'b1);
        test_random_traffic(17, 0, 63, 1'b0);
        test_random_traffic(17, 6, 6, 1'b0);
        wait_quiet(SETTLE_CYCLES);
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
